// ----- rtl/drp_pkg.sv -----
// Shared types and constants for the disparity reprojection core.
// Used by drp_prep, drp_cell and disparity_reproject_3d_core; no dependencies.
package drp_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int NUM_BITS = 34;              // Q16.16 numerator, signed
	localparam int W_BITS = 49;                // w in Q.20, signed
	localparam int FRAC_SHIFT = 20;
	localparam int DVD_BITS = NUM_BITS + FRAC_SHIFT;
	localparam int QUO_BITS = 33;
	localparam int LANES = 3;

	localparam logic [2:0] REG_OFFSET_X = 3'd0;
	localparam logic [2:0] REG_OFFSET_Y = 3'd1;
	localparam logic [2:0] REG_FOCAL_TERM = 3'd2;
	localparam logic [2:0] REG_DISP_GAIN = 3'd3;
	localparam logic [2:0] REG_DENOM_BIAS = 3'd4;

	localparam logic [31:0] BIAS_RESET = 32'h0001_0000;

	typedef struct packed {
		logic [W_BITS-1:0]   rem;
		logic [DVD_BITS-1:0] dvd;
		logic [QUO_BITS-1:0] quo;
		logic                ovf;
		logic                nsign;   // numerator negative
		logic                nzero;   // numerator zero
	} lane_t;

	typedef struct packed {
		logic                valid;
		logic [W_BITS-1:0]   dmag;    // |w|
		logic                wsign;
		logic                wzero;
		logic [23:0]         bgr;
		lane_t [LANES-1:0]   lane;
	} cell_t;

endpackage

// ----- rtl/disparity_reproject_3d_core.sv -----
// Top level of the disparity-to-3D reprojection core: config registers,
// front end, divider chain and saturating output register.
// Depends on drp_pkg, drp_prep, drp_cell.
//
// Channel  Dir  Fields (low bit up)
// s_*      in   tdata: pixel_row[11:0] pixel_col[23:12] disparity[39:24] colour_bgr[63:40]
// m_*      out  tdata: point_x point_y point_z red green blue; tuser: saturated
// cfg_*    in   cfg_index selects register, cfg_data is the value
//
// One pixel per cycle; pipeline: 2 front-end stages, 54 divider cells (one
// quotient bit each, their number set by the dividend width), 1 output stage.
// The whole pipe advances together; it stalls only while a result waits in
// the output register and m_tready is low. Pixels with disparity <= 0 drop.
// Reset clears valid bits and loads the config register defaults.
module disparity_reproject_3d_core #(
	parameter int COORD_BITS = drp_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // pixel_row, pixel_col, disparity, colour_bgr
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // point_x, point_y, point_z, red, green, blue
	output logic         m_tuser,   // saturated
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int NCELLS = drp_pkg::DVD_BITS;

	logic [31:0] off_x_q, off_y_q, focal_q, gain_q, bias_q;
	logic        adv;
	drp_pkg::cell_t chain [NCELLS+1];
	drp_pkg::cell_t last;

	logic [31:0] res [drp_pkg::LANES];
	logic        sat;
	logic        out_v_q;
	logic [95:0] pt_q;
	logic [23:0] rgb_q;
	logic        sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			focal_q <= '0;
			gain_q  <= '0;
			bias_q  <= drp_pkg::BIAS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				drp_pkg::REG_OFFSET_X:   off_x_q <= cfg_data;
				drp_pkg::REG_OFFSET_Y:   off_y_q <= cfg_data;
				drp_pkg::REG_FOCAL_TERM: focal_q <= cfg_data;
				drp_pkg::REG_DISP_GAIN:  gain_q  <= cfg_data;
				drp_pkg::REG_DENOM_BIAS: bias_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv = !out_v_q || m_tready;
	assign s_tready = adv;

	drp_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.in_valid(s_tvalid),
		.row(s_tdata[11:0]), .col(s_tdata[23:12]),
		.disp($signed(s_tdata[39:24])), .bgr(s_tdata[63:40]),
		.off_x(off_x_q), .off_y(off_y_q), .focal(focal_q),
		.gain(gain_q), .bias(bias_q),
		.cell_out(chain[0])
	);

	for (genvar g = 0; g < NCELLS; g++) begin : g_cell
		drp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv),
			.cell_in(chain[g]), .cell_out(chain[g+1])
		);
	end

	assign last = chain[NCELLS];

	always_comb begin
		logic neg;
		logic big;
		logic [drp_pkg::QUO_BITS-1:0] q;
		sat = 1'b0;
		for (int i = 0; i < drp_pkg::LANES; i++) begin
			q = last.lane[i].quo;
			neg = last.lane[i].nsign ^ last.wsign;
			big = last.lane[i].ovf || (neg ? (q > 33'h0_8000_0000) : (q > 33'h0_7FFF_FFFF));
			if (last.wzero) begin
				sat = 1'b1;
				res[i] = last.lane[i].nzero ? 32'h0 :
				         (last.lane[i].nsign ? 32'h8000_0000 : 32'h7FFF_FFFF);
			end else if (big) begin
				sat = 1'b1;
				res[i] = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				res[i] = neg ? 32'(-q) : q[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_q  <= {res[2], res[1], res[0]};
			// BGR in; red lands in the low byte, blue on top
			rgb_q <= {last.bgr[7:0], last.bgr[15:8], last.bgr[23:16]};
			sat_q <= sat;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {rgb_q, pt_q};
	assign m_tuser  = sat_q;

endmodule

// ----- rtl/drp_prep.sv -----
// Front end: forms w = gain*d + bias*16 and the three numerators, splits them
// into sign and magnitude for the divider chain. Depends on drp_pkg.
module drp_prep #(
	parameter int COORD_BITS = drp_pkg::COORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [11:0]       row,
	input  logic [11:0]       col,
	input  logic signed [15:0] disp,
	input  logic [23:0]       bgr,
	input  logic [31:0]       off_x,
	input  logic [31:0]       off_y,
	input  logic [31:0]       focal,
	input  logic [31:0]       gain,
	input  logic [31:0]       bias,
	output drp_pkg::cell_t    cell_out
);

	localparam logic [11:0] CMASK = 12'((64'd1 << COORD_BITS) - 64'd1);

	logic                     valid_s1;
	logic [11:0]              row_s1, col_s1;
	logic [23:0]              bgr_s1;
	logic signed [47:0]       prod_s1;
	logic signed [47:0]       prod;
	logic signed [drp_pkg::W_BITS-1:0]   w;
	logic signed [drp_pkg::NUM_BITS-1:0] num [drp_pkg::LANES];
	drp_pkg::cell_t           c;
	logic                     valid_s2;
	drp_pkg::cell_t           data_s2;

	assign prod = $signed(gain) * disp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid && (disp > 16'sd0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1  <= row & CMASK;
			col_s1  <= col & CMASK;
			bgr_s1  <= bgr;
			prod_s1 <= prod;
		end
	end

	always_comb begin
		w = 49'(prod_s1) + $signed({{13{bias[31]}}, bias, 4'd0});
		num[0] = -(34'($signed(off_x)) + $signed({6'd0, col_s1, 16'd0}));
		num[1] = -(34'($signed(off_y)) + $signed({6'd0, row_s1, 16'd0}));
		num[2] = 34'($signed(focal));
		c = '0;
		c.valid = valid_s1;
		c.wsign = w[drp_pkg::W_BITS-1];
		c.wzero = (w == '0);
		c.dmag  = w[drp_pkg::W_BITS-1] ? drp_pkg::W_BITS'(-w) : drp_pkg::W_BITS'(w);
		c.bgr   = bgr_s1;
		for (int i = 0; i < drp_pkg::LANES; i++) begin
			c.lane[i].nsign = num[i][drp_pkg::NUM_BITS-1];
			c.lane[i].nzero = (num[i] == '0);
			c.lane[i].dvd   = {(num[i][drp_pkg::NUM_BITS-1] ?
				drp_pkg::NUM_BITS'(-num[i]) : drp_pkg::NUM_BITS'(num[i])),
				{drp_pkg::FRAC_SHIFT{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= c.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= c;
		end
	end

	always_comb begin
		cell_out = data_s2;
		cell_out.valid = valid_s2;
	end

endmodule

// ----- rtl/drp_cell.sv -----
// One restoring-division cell: one quotient bit for each of the three lanes,
// then hands remainder and dividend to the next cell. Depends on drp_pkg.
module drp_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  drp_pkg::cell_t cell_in,
	output drp_pkg::cell_t cell_out
);

	drp_pkg::cell_t  nxt;
	logic [drp_pkg::W_BITS:0] trial [drp_pkg::LANES];
	logic            ge [drp_pkg::LANES];
	logic            valid_q;
	drp_pkg::cell_t  data_q;

	always_comb begin
		nxt = cell_in;
		for (int i = 0; i < drp_pkg::LANES; i++) begin
			trial[i] = {cell_in.lane[i].rem, cell_in.lane[i].dvd[drp_pkg::DVD_BITS-1]};
			ge[i] = trial[i] >= {1'b0, cell_in.dmag};
			nxt.lane[i].rem = ge[i] ? drp_pkg::W_BITS'(trial[i] - {1'b0, cell_in.dmag})
			                        : drp_pkg::W_BITS'(trial[i]);
			nxt.lane[i].dvd = cell_in.lane[i].dvd << 1;
			nxt.lane[i].quo = {cell_in.lane[i].quo[drp_pkg::QUO_BITS-2:0], ge[i]};
			// a bit pushed out of the top means the quotient cannot fit
			nxt.lane[i].ovf = cell_in.lane[i].ovf | cell_in.lane[i].quo[drp_pkg::QUO_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	always_comb begin
		cell_out = data_q;
		cell_out.valid = valid_q;
	end

endmodule
